### hw/rtl/sha256c_pkg.sv
// Shared types, constants and round functions for the SHA-256 compression block.
package sha256c_pkg;

   localparam int WORD_W      = 32;
   localparam int CHAIN_WORDS = 8;
   localparam int BLOCK_WORDS = 16;
   localparam int ROUNDS      = 64;
   localparam int CHAIN_IDX_W = $clog2(CHAIN_WORDS);
   localparam int BLOCK_CNT_W = $clog2(BLOCK_WORDS);
   localparam int ROUND_W     = $clog2(ROUNDS);

   // Configuration port: one register at byte addresses 0..3 of the 0..7 space.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_BYTE_SWAP = 1'b0;

   // Request action codes.
   localparam logic ACT_LOAD_CHAIN = 1'b0;
   localparam logic ACT_ABSORB     = 1'b1;

   typedef logic [WORD_W-1:0] word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                   load_chain;
      logic                   absorb;
      logic                   start;
      logic                   round;
      logic [ROUND_W-1:0]     round_idx;
      logic                   fold;
      logic [CHAIN_IDX_W-1:0] emit_idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic block_full;
   } status_type;

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

### hw/rtl/sha256c_if.sv
// Request and response channel interfaces for the SHA-256 compression block.
interface sha256c_req_if import sha256c_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   action;
   logic [CHAIN_IDX_W-1:0] chain_index;
   word_type               data_word;

   modport source (output valid, action, chain_index, data_word, input ready);
   modport sink   (input valid, action, chain_index, data_word, output ready);
endinterface

interface sha256c_rsp_if import sha256c_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CHAIN_IDX_W-1:0] digest_index;
   word_type               digest_word;
   logic                   last;

   modport source (output valid, digest_index, digest_word, last, input ready);
   modport sink   (input valid, digest_index, digest_word, last, output ready);
endinterface

### hw/rtl/sha256c_ctrl.sv
// Controller state machine: request intake, round sequencing, digest output.
module sha256c_ctrl import sha256c_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_action,
   output logic                   req_ready,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic                   rsp_last,
   output logic [CHAIN_IDX_W-1:0] rsp_digest_index,
   input  status_type             status,
   output cmd_type                cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [ROUND_W-1:0]     round_ff, round_in;
   logic [CHAIN_IDX_W-1:0] emit_ff, emit_in;
   logic                   accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.load_chain = accept && (req_action == ACT_LOAD_CHAIN);
      cmd.absorb     = accept && (req_action == ACT_ABSORB);
      cmd.start      = cmd.absorb && status.block_full;
      cmd.round      = (state_ff == ST_ROUND);
      cmd.round_idx  = round_ff;
      cmd.fold       = (state_ff == ST_FOLD);
      cmd.emit_idx   = emit_ff;
   end

   assign rsp_valid        = (state_ff == ST_EMIT);
   assign rsp_digest_index = emit_ff;
   assign rsp_last         = (emit_ff == CHAIN_IDX_W'(CHAIN_WORDS - 1));

   always_comb begin
      state_in = state_ff;
      round_in = round_ff;
      emit_in  = emit_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_ROUND;
               round_in = '0;
            end
         end
         ST_ROUND: begin
            round_in = round_ff + 1'b1;
            if (round_ff == ROUND_W'(ROUNDS - 1)) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            state_in = ST_EMIT;
            emit_in  = '0;
         end
         ST_EMIT: begin
            if (rsp_ready) begin
               emit_in = emit_ff + 1'b1;
               if (rsp_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         round_ff <= '0;
         emit_ff  <= '0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
         emit_ff  <= emit_in;
      end
   end

endmodule

### hw/rtl/sha256c_dp.sv
// Datapath: chaining words, message window, working variables and round logic.
module sha256c_dp import sha256c_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   input  logic                   byte_swap,
   input  logic [CHAIN_IDX_W-1:0] chain_index,
   input  word_type               data_word,
   output word_type               digest_word,
   output status_type             status
);

   word_type               cv_ff [CHAIN_WORDS];
   word_type               cv_in [CHAIN_WORDS];
   word_type               w_ff  [BLOCK_WORDS];
   word_type               w_in  [BLOCK_WORDS];
   word_type               v_ff  [CHAIN_WORDS];
   word_type               v_in  [CHAIN_WORDS];
   logic [BLOCK_CNT_W-1:0] wcnt_ff, wcnt_in;

   word_type msg_word;
   word_type sched_next;
   word_type t1;
   word_type t2;

   assign msg_word = byte_swap ?
      {data_word[7:0], data_word[15:8], data_word[23:16], data_word[31:24]} : data_word;

   // Window holds W[r]..W[r+15]; the new word enters at the top.
   assign sched_next = small_sigma1(w_ff[14]) + w_ff[9] + small_sigma0(w_ff[1]) + w_ff[0];

   assign t1 = v_ff[7] + big_sigma1(v_ff[4]) + (v_ff[6] ^ (v_ff[4] & (v_ff[5] ^ v_ff[6])))
             + ROUND_K[cmd.round_idx] + w_ff[0];
   assign t2 = big_sigma0(v_ff[0])
             + ((v_ff[0] & v_ff[1]) | (v_ff[2] & (v_ff[0] | v_ff[1])));

   assign digest_word       = cv_ff[cmd.emit_idx];
   assign status.block_full = (wcnt_ff == BLOCK_CNT_W'(BLOCK_WORDS - 1));

   always_comb begin
      cv_in   = cv_ff;
      w_in    = w_ff;
      v_in    = v_ff;
      wcnt_in = wcnt_ff;

      if (cmd.load_chain) begin
         cv_in[chain_index] = data_word;
      end
      if (cmd.fold) begin
         for (int i = 0; i < CHAIN_WORDS; i++) begin
            cv_in[i] = cv_ff[i] + v_ff[i];
         end
      end

      if (cmd.absorb || cmd.round) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
            w_in[i] = w_ff[i + 1];
         end
         w_in[BLOCK_WORDS - 1] = cmd.absorb ? msg_word : sched_next;
      end
      if (cmd.absorb) begin
         wcnt_in = wcnt_ff + 1'b1;
      end

      if (cmd.start) begin
         v_in = cv_ff;
      end else if (cmd.round) begin
         for (int i = 1; i < CHAIN_WORDS; i++) begin
            v_in[i] = v_ff[i - 1];
         end
         v_in[4] = v_ff[3] + t1;
         v_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHAIN_WORDS; i++) begin
            cv_ff[i] <= '0;
         end
         wcnt_ff <= '0;
      end else begin
         cv_ff   <= cv_in;
         wcnt_ff <= wcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
   end

endmodule

### hw/rtl/sha256_block_compress.sv
// Top level of the SHA-256 compression block: channels, CSR port, checks.
//
//   channel   dir   handshake               payload
//   req_chan  in    valid / ready           action, chain_index, data_word
//   rsp_chan  out   valid / ready           digest_index, digest_word, last
//   csr_*     in    psel/penable, pready=1  paddr, pwdata, prdata (byte_swap)
//
// A chaining-word load or a message word is taken while idle.
// The sixteenth message word starts the rounds (one round per cycle in the
// round unit), then a fold, then eight digest words, one per cycle while
// rsp_chan.ready is high.
// No request is taken from the sixteenth word until the last digest word leaves.
// Synchronous reset clears the chaining words, word count and byte_swap.
// Stalls on rsp_chan hold the current digest word and its index.
module sha256_block_compress import sha256c_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sha256c_req_if.sink           req_chan,
   sha256c_rsp_if.source         rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cmd_type    cmd;
   status_type status;

   logic byte_swap_ff, byte_swap_in;
   logic csr_write;
   logic csr_hit;

   // CSR port: zero wait states; the byte offset inside a register is ignored.
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_BYTE_SWAP);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Writes outside the register list are dropped.
   assign byte_swap_in = (csr_write && csr_hit) ? csr_pwdata[0] : byte_swap_ff;
   assign csr_prdata   = csr_hit ? {{(CSR_DATA_W-1){1'b0}}, byte_swap_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_swap_ff <= 1'b0;
      end else begin
         byte_swap_ff <= byte_swap_in;
      end
   end

   // Controller owns the handshakes and sequencing.
   sha256c_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_chan.valid),
      .req_action       (req_chan.action),
      .req_ready        (req_chan.ready),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_last         (rsp_chan.last),
      .rsp_digest_index (rsp_chan.digest_index),
      .status           (status),
      .cmd              (cmd)
   );

   // Datapath holds the hash state and runs one round per cycle.
   sha256c_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .byte_swap   (byte_swap_ff),
      .chain_index (req_chan.chain_index),
      .data_word   (req_chan.data_word),
      .digest_word (rsp_chan.digest_word),
      .status      (status)
   );

   // Never take a request while a digest word is on offer.
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.valid && req_chan.ready && rsp_chan.valid))
      else $error("request accepted while digest output pending");

   // A completed block closes intake on the next cycle.
   a_full_block_stalls: assert property (@(posedge clock) disable iff (reset)
      (cmd.start) |=> !req_chan.ready)
      else $error("intake still open after sixteenth word");

   // The last digest word leaves the block ready for the next request.
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last) |=> req_chan.ready)
      else $error("intake not reopened after last digest word");

   // The last marker goes with the top chaining word only.
   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.last) |->
         (rsp_chan.digest_index == CHAIN_IDX_W'(CHAIN_WORDS - 1)))
      else $error("last marker on wrong digest index");

endmodule

### tb/sha256c_digest_checker.sv
// Watches the SHA-256 compression channels, predicts each digest word and compares.
`timescale 1ns / 100ps

module sha256c_digest_checker import sha256c_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   sha256c_req_if                req_mon,
   sha256c_rsp_if                rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output int                    mismatches,
   output int                    outstanding,
   output int                    digests_seen,
   output int                    swapped_blocks,
   output int                    native_blocks
);

   typedef struct packed {
      logic [CHAIN_IDX_W-1:0] index;
      word_type               word;
      logic                   last;
   } digest_word_type;

   localparam word_type ROUND_CONST [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   word_type               chain_val [CHAIN_WORDS];
   word_type               msg_blk [BLOCK_WORDS];
   logic [BLOCK_CNT_W-1:0] word_cnt;
   logic                   swap_en;
   digest_word_type        digest_q [$];
   digest_word_type        seen;
   digest_word_type        want;

   function automatic word_type rotr(input word_type x, input int n);
      return (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic word_type flip_bytes(input word_type x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   // 64 rounds over the held block with a rolling 16-entry schedule,
   // then fold the working variables into the chaining value.
   function automatic void compress_block();
      word_type w [BLOCK_WORDS];
      word_type v [CHAIN_WORDS];
      word_type wr, t1, t2, a, b;
      w = msg_blk;
      v = chain_val;
      for (int r = 0; r < ROUNDS; r++) begin
         if (r < BLOCK_WORDS) begin
            wr = w[r];
         end else begin
            a  = w[(r + 1) % BLOCK_WORDS];
            b  = w[(r + 14) % BLOCK_WORDS];
            wr = (rotr(b, 17) ^ rotr(b, 19) ^ (b >> 10)) + w[(r + 9) % BLOCK_WORDS]
               + (rotr(a, 7) ^ rotr(a, 18) ^ (a >> 3)) + w[r % BLOCK_WORDS];
            w[r % BLOCK_WORDS] = wr;
         end
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + (v[6] ^ (v[4] & (v[5] ^ v[6]))) + ROUND_CONST[r] + wr;
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < CHAIN_WORDS; i++)
         chain_val[i] = chain_val[i] + v[i];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         foreach (chain_val[i]) chain_val[i] = '0;
         word_cnt       = '0;
         swap_en        = 1'b0;
         mismatches     = 0;
         digests_seen   = 0;
         swapped_blocks = 0;
         native_blocks  = 0;
         digest_q.delete();
         outstanding   <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_BYTE_SWAP)
            swap_en = csr_pwdata[0];

         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{index: rsp_mon.digest_index, word: rsp_mon.digest_word,
                     last: rsp_mon.last};
            digests_seen++;
            if (digest_q.size() == 0) begin
               $display("%0t: unexpected digest word: index %0d word %h last %b",
                        $time, seen.index, seen.word, seen.last);
               mismatches++;
            end else begin
               want = digest_q.pop_front();
               if (seen !== want) begin
                  $display("%0t: digest mismatch: expected index %0d word %h last %b, got index %0d word %h last %b",
                           $time, want.index, want.word, want.last,
                           seen.index, seen.word, seen.last);
                  mismatches++;
               end
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.action == ACT_LOAD_CHAIN) begin
               chain_val[req_mon.chain_index] = req_mon.data_word;
            end else begin
               msg_blk[word_cnt] = swap_en ? flip_bytes(req_mon.data_word)
                                           : req_mon.data_word;
               if (word_cnt == BLOCK_WORDS - 1) begin
                  compress_block();
                  if (swap_en) swapped_blocks++;
                  else native_blocks++;
                  for (int i = 0; i < CHAIN_WORDS; i++) begin
                     want = '{index: CHAIN_IDX_W'(i), word: chain_val[i],
                              last: (i == CHAIN_WORDS - 1)};
                     digest_q.push_back(want);
                  end
               end
               word_cnt = word_cnt + 1'b1;
            end
         end

         outstanding <= digest_q.size();
      end
   end

endmodule

### tb/tb_top.sv
// Top of the SHA-256 compression testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
   import sha256c_pkg::*;

   // Byte addresses on the CSR port: the live register and one past the map.
   localparam logic [CSR_ADDR_W-1:0] ADDR_BYTE_SWAP = {CSR_IDX_BYTE_SWAP, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED  = {~CSR_IDX_BYTE_SWAP, 2'b00};

   localparam int STALL_LIMIT    = 2000;  // cycles with no handshake at all
   localparam int PHASES         = 4;
   localparam int PHASE_REQUESTS = 32;
   localparam int IDLE_PCT       = 34;
   localparam int SETTLE_CYCLES  = 8;     // block is idle again the cycle after the last digest word
   localparam int TAIL_CYCLES    = 100;   // settle time after the last phase

   // Initial hash value and the single-block "abc" message.
   localparam word_type SHA256_IV [CHAIN_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };
   localparam word_type ABC_HEAD   = 32'h61626380;
   localparam word_type ABC_LENGTH = 32'h00000018;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bit gaps_on;       // random idling on both channels
   int req_count;
   int load_count;
   int stall_cycles;
   int phase_start;

   int mismatches;
   int outstanding;
   int digests_seen;
   int swapped_blocks;
   int native_blocks;

   sha256c_req_if req_chan ();
   sha256c_rsp_if rsp_chan ();

   sha256_block_compress DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sha256c_digest_checker digest_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatches     (mismatches),
      .outstanding    (outstanding),
      .digests_seen   (digests_seen),
      .swapped_blocks (swapped_blocks),
      .native_blocks  (native_blocks)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the digest side at random while gaps are on; keep it open otherwise.
   always @(posedge clock) begin
      rsp_chan.ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
   end

   // Drop the run when nothing moves for too long: a hung block or a lost word.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready) || (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d digest words still due",
                  $time, stall_cycles, outstanding);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Mostly random words, with the all-zero and all-one patterns now and then.
   function automatic word_type rand_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Offer one request and hold it until the block takes it. Valid stays high
   // on return so back-to-back requests follow without a gap.
   task automatic send_req(input logic act, input logic [CHAIN_IDX_W-1:0] idx,
                           input word_type data);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.action      <= act;
      req_chan.chain_index <= idx;
      req_chan.data_word   <= data;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      req_count++;
      if (act == ACT_LOAD_CHAIN) load_count++;
   endtask

   // Setup cycle, then access cycle; the register updates when pready is seen.
   // Return after the port goes idle so writes can follow each other.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid, wait for every predicted digest word, then let the block settle.
   task automatic drain(input int settle);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (settle) @(posedge clock);
   endtask

   initial begin
      reset                = 1'b1;
      gaps_on              = 1'b1;
      req_count            = 0;
      load_count           = 0;
      req_chan.valid       = 1'b0;
      req_chan.action      = ACT_LOAD_CHAIN;
      req_chan.chain_index = '0;
      req_chan.data_word   = '0;
      rsp_chan.ready       = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: native byte order, standard IV, the "abc" block. A chaining
      // load of all ones lands halfway through the block, so the partial
      // block must survive it and the new word must feed the compression.
      csr_write(ADDR_BYTE_SWAP, 0);
      for (int i = 0; i < CHAIN_WORDS; i++)
         send_req(ACT_LOAD_CHAIN, CHAIN_IDX_W'(i), SHA256_IV[i]);
      for (int w = 0; w < BLOCK_WORDS; w++) begin
         if (w == BLOCK_WORDS / 2)
            send_req(ACT_LOAD_CHAIN, '0, '1);
         send_req(ACT_ABSORB, CHAIN_IDX_W'($urandom_range(CHAIN_WORDS - 1)),
                  (w == 0) ? ABC_HEAD : (w == BLOCK_WORDS - 1) ? ABC_LENGTH : '0);
      end
      drain(SETTLE_CYCLES);

      // Random phases. Byte order alternates, starting swapped; the third
      // phase runs with no idling on either side.
      for (int phase = 0; phase < PHASES; phase++) begin
         csr_write(ADDR_BYTE_SWAP, (phase % 2 == 0) ? 1 : 0);
         // A write past the register map must leave the byte order alone.
         if (phase == 0)
            csr_write(ADDR_UNMAPPED, 0);
         gaps_on     = (phase != 2);
         phase_start = req_count;
         while (req_count - phase_start < PHASE_REQUESTS) begin
            if ($urandom_range(9) == 0) begin
               // Stray requests: a broken block that shifts the word alignment.
               repeat ($urandom_range(6, 1))
                  send_req($urandom_range(1) ? ACT_ABSORB : ACT_LOAD_CHAIN,
                           CHAIN_IDX_W'($urandom_range(CHAIN_WORDS - 1)), rand_word());
            end else begin
               // Well-formed: fresh chaining value (full or partial), then a
               // block of sixteen words with the odd chaining load inside it.
               if ($urandom_range(4) == 0) begin
                  for (int i = 0; i < CHAIN_WORDS; i++)
                     send_req(ACT_LOAD_CHAIN, CHAIN_IDX_W'(i), rand_word());
               end else begin
                  repeat ($urandom_range(2))
                     send_req(ACT_LOAD_CHAIN,
                              CHAIN_IDX_W'($urandom_range(CHAIN_WORDS - 1)), rand_word());
               end
               for (int w = 0; w < BLOCK_WORDS; w++) begin
                  if ($urandom_range(9) == 0)
                     send_req(ACT_LOAD_CHAIN,
                              CHAIN_IDX_W'($urandom_range(CHAIN_WORDS - 1)), rand_word());
                  send_req(ACT_ABSORB, CHAIN_IDX_W'($urandom_range(CHAIN_WORDS - 1)),
                           rand_word());
               end
            end
         end
         drain((phase == PHASES - 1) ? TAIL_CYCLES : SETTLE_CYCLES);
      end

      $display("Sent %0d requests (%0d chaining loads) over %0d phases with idling and stalls",
               req_count, load_count, PHASES + 1);
      $display("Checked %0d digest words from %0d native and %0d byte-swapped blocks",
               digests_seen, native_blocks, swapped_blocks);
      if (mismatches == 0 && outstanding == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
